>>> rtl/core/sch_pkg.sv
// Shared types, constants and helpers for the trend cycle block.
package sch_pkg;

   localparam int CLOSE_W    = 32;
   localparam int PERIOD_W   = 10;
   localparam int CYCLE_W    = 7;
   localparam int CSR_ADDR_W = 2;
   localparam int OUT_W      = 15;
   localparam int RATIO_BITS = 30;
   localparam int PCT_W      = 23;

   localparam logic [PCT_W-1:0] PCT_HALF = PCT_W'(3276800);
   localparam logic [OUT_W-1:0] OUT_MAX  = OUT_W'(25600);

   localparam logic [CSR_ADDR_W-1:0] CSR_FAST_PERIOD  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SLOW_PERIOD  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CYCLE_LENGTH = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FAST_GO,
      ST_FAST_WAIT,
      ST_SLOW_GO,
      ST_SLOW_WAIT,
      ST_DIFF,
      ST_SCAN,
      ST_RATIO,
      ST_DIV_WAIT,
      ST_PCT,
      ST_SMOOTH,
      ST_DONE
   } sch_state_type;

   typedef struct packed {
      logic wr_diff;
      logic wr_smooth;
      logic rd_en;
      logic rd_smooth;
   } sch_mem_ctl_type;

   // Period-3 average step on percent values: move by round(|d| / 2).
   function automatic logic [PCT_W-1:0] ema3(input logic [PCT_W-1:0] prev,
                                             input logic [PCT_W-1:0] x);
      logic signed [PCT_W:0] d;
      logic [PCT_W-1:0]      mag;
      logic [PCT_W-1:0]      q;
      d   = signed'({1'b0, x}) - signed'({1'b0, prev});
      mag = d[PCT_W] ? PCT_W'(-d) : d[PCT_W-1:0];
      q   = PCT_W'(({1'b0, mag} + (PCT_W+1)'(1)) >> 1);
      return d[PCT_W] ? (prev - q) : (prev + q);
   endfunction

endpackage

>>> rtl/core/schaff_trend_cycle.sv
// Schaff trend cycle: sequencer, averages and window scans around one shared divider.
//
// Usage: one closing price (signed Q16.16) per input word on req_tdata, with
// req_tuser set on the first bar of a new series. Each input word produces one
// result word on rsp_tdata: the trend cycle value in Q8.8, 0 to 100.
// Periods and window length are written through the csr port; the user must write them
// only while idle, which the block leaves unchecked. One bar at a time: req_tready is
// high only in the idle state. The shared divider, DIV_W = FRACTION_BITS+35 bits wide
// (51 at default), gives one quotient bit a cycle for each of the two price averages
// and the two stochastic ratios. Each window scan reads one history entry a cycle from
// the ring memories. The finished value waits in an output register; the next bar
// is accepted as soon as it is loaded, and a stalled receiver holds only the final
// step of the following bar. Reset clears the sequencer, the bar count, the ring
// position and the output valid flag, and restores the default periods and window
// length; the history memories need no clearing since the window never reaches an
// entry not written this series.
module schaff_trend_cycle #(
   parameter int WINDOW_MAX    = 64,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [31:0]                         req_tdata,   // [31:0] close_price
   input  logic                                req_tuser,   // [0] restart
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [15:0]                         rsp_tdata,   // [14:0] trend_value
   input  logic                                csr_wr_en,
   input  logic [sch_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [sch_pkg::PERIOD_W-1:0]        csr_wdata
);
   import sch_pkg::*;

   localparam int AVG_W  = CLOSE_W + FRACTION_BITS;
   localparam int DIFF_W = AVG_W + 1;
   localparam int DIV_W  = DIFF_W + 2;
   localparam int CW     = $clog2(DIV_W + 1);
   localparam int AW     = $clog2(WINDOW_MAX);
   localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
   localparam int CYW    = (CNT_W > CYCLE_W) ? CNT_W : CYCLE_W;
   localparam int PROD_W = RATIO_BITS + 1 + 7;

   sch_state_type state_ff, state_in;

   logic [PERIOD_W-1:0]      fast_period_ff, slow_period_ff;
   logic [CYCLE_W-1:0]       cycle_length_ff;
   logic [CLOSE_W-1:0]       close_ff;
   logic                     first_ff, stage2_ff, neg_ff;
   logic signed [AVG_W-1:0]  fast_ff, slow_ff;
   logic signed [DIFF_W-1:0] v_ff, lo_ff, hi_ff;
   logic [AW-1:0]            rd_addr_ff, pos_ff;
   logic [CNT_W-1:0]         iss_ff, bars_ff;
   logic                     pend_ff;
   logic [RATIO_BITS:0]      ratio_ff;
   logic [PCT_W-1:0]         pct_ff, smooth_ff, final_ff;
   logic                     rsp_valid_ff;
   logic [OUT_W-1:0]         rsp_data_ff;

   // combinational datapath
   logic signed [AVG_W-1:0]  x_c, prev_c;
   logic [PERIOD_W-1:0]      per_lo_c, per_hi_c, per_c, per_fix_c;
   logic [PERIOD_W:0]        den_c;
   logic signed [AVG_W:0]    d_c;
   logic [AVG_W-1:0]         mag_c;
   logic [DIV_W-1:0]         num_c;
   logic [DIFF_W-1:0]        a_c, b_c;
   logic                     flat_c, full_c;
   logic signed [DIFF_W-1:0] diff_c, sample_c;
   logic [CYW-1:0]           cyc_c;
   logic [CNT_W-1:0]         count_c, win_c;
   logic [AW-1:0]            pos_dec_c, rd_dec_c;
   logic [PCT_W-1:0]         sm_new_c, fin_new_c;
   logic [PROD_W-1:0]        pct_sum_c;
   logic [PCT_W:0]           out_rnd_c;
   logic                     scan_done_c, out_free_c;

   // divider and memory hookup
   logic                     div_start, div_done;
   logic [DIV_W-1:0]         div_rem, div_num, div_den, div_quot;
   logic [CW-1:0]            div_iters;
   sch_mem_ctl_type          mem_ctl;
   logic signed [DIFF_W-1:0] rd_diff;
   logic [PCT_W-1:0]         rd_smooth;

   assign x_c      = signed'({close_ff, {FRACTION_BITS{1'b0}}});
   assign per_lo_c = (fast_period_ff > slow_period_ff) ? slow_period_ff : fast_period_ff;
   assign per_hi_c = (fast_period_ff > slow_period_ff) ? fast_period_ff : slow_period_ff;
   assign per_c    = (state_ff == ST_SLOW_GO) ? per_hi_c : per_lo_c;
   assign per_fix_c = (per_c == '0) ? PERIOD_W'(1) : per_c;
   assign den_c    = {1'b0, per_fix_c} + (PERIOD_W+1)'(1);
   assign prev_c   = (state_ff == ST_SLOW_GO) ? slow_ff : fast_ff;
   assign d_c      = {x_c[AVG_W-1], x_c} - {prev_c[AVG_W-1], prev_c};
   assign mag_c    = d_c[AVG_W] ? AVG_W'(-d_c) : d_c[AVG_W-1:0];
   assign num_c    = DIV_W'({mag_c, 1'b0}) + DIV_W'(den_c >> 1);

   assign a_c    = DIFF_W'(v_ff - lo_ff);
   assign b_c    = DIFF_W'(hi_ff - lo_ff);
   assign flat_c = (hi_ff == lo_ff);
   assign full_c = (a_c >= b_c);

   assign diff_c = {fast_ff[AVG_W-1], fast_ff} - {slow_ff[AVG_W-1], slow_ff};
   assign sample_c = stage2_ff ? signed'({{(DIFF_W-PCT_W){1'b0}}, rd_smooth}) : rd_diff;

   always_comb begin
      cyc_c = CYW'(cycle_length_ff);
      if (cyc_c == '0) begin
         cyc_c = CYW'(1);
      end else if (cyc_c > CYW'(WINDOW_MAX)) begin
         cyc_c = CYW'(WINDOW_MAX);
      end
   end

   assign count_c = (bars_ff == CNT_W'(WINDOW_MAX)) ? bars_ff : bars_ff + CNT_W'(1);
   assign win_c   = (cyc_c < CYW'(count_c)) ? CNT_W'(cyc_c) : count_c;
   assign pos_dec_c = (pos_ff == '0) ? AW'(WINDOW_MAX - 1) : pos_ff - AW'(1);
   assign rd_dec_c  = (rd_addr_ff == '0) ? AW'(WINDOW_MAX - 1) : rd_addr_ff - AW'(1);

   assign sm_new_c  = first_ff ? pct_ff : ema3(smooth_ff, pct_ff);
   assign fin_new_c = first_ff ? pct_ff : ema3(final_ff, pct_ff);
   assign pct_sum_c = PROD_W'(ratio_ff) * PROD_W'(100) + PROD_W'(8192);
   assign out_rnd_c = ({1'b0, final_ff} + (PCT_W+1)'(128)) >> 8;

   assign scan_done_c = (iss_ff == '0) && !pend_ff;
   assign out_free_c  = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_tvalid) state_in = ST_FAST_GO;
         ST_FAST_GO:   state_in = first_ff ? ST_DIFF : ST_FAST_WAIT;
         ST_FAST_WAIT: if (div_done) state_in = ST_SLOW_GO;
         ST_SLOW_GO:   state_in = ST_SLOW_WAIT;
         ST_SLOW_WAIT: if (div_done) state_in = ST_DIFF;
         ST_DIFF:      state_in = ST_SCAN;
         ST_SCAN:      if (scan_done_c) state_in = ST_RATIO;
         ST_RATIO: begin
            if (flat_c)      state_in = ST_SMOOTH;
            else if (full_c) state_in = ST_PCT;
            else             state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT:  if (div_done) state_in = ST_PCT;
         ST_PCT:       state_in = ST_SMOOTH;
         ST_SMOOTH:    state_in = stage2_ff ? ST_DONE : ST_SCAN;
         ST_DONE:      if (out_free_c) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready        = 1'b0;
      div_start         = 1'b0;
      div_rem           = '0;
      div_num           = num_c;
      div_den           = DIV_W'(den_c);
      div_iters         = CW'(DIV_W);
      mem_ctl.wr_diff   = 1'b0;
      mem_ctl.wr_smooth = 1'b0;
      mem_ctl.rd_en     = 1'b0;
      mem_ctl.rd_smooth = stage2_ff;
      unique case (state_ff)
         ST_IDLE:    req_tready = 1'b1;
         ST_FAST_GO: div_start = !first_ff;
         ST_SLOW_GO: div_start = 1'b1;
         ST_DIFF:    mem_ctl.wr_diff = 1'b1;
         ST_SCAN:    mem_ctl.rd_en = (iss_ff != '0);
         ST_RATIO: begin
            div_start = !flat_c && !full_c;
            div_rem   = DIV_W'(a_c);
            div_num   = '0;
            div_den   = DIV_W'(b_c);
            div_iters = CW'(RATIO_BITS);
         end
         ST_SMOOTH:  mem_ctl.wr_smooth = !stage2_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         fast_period_ff  <= PERIOD_W'(23);
         slow_period_ff  <= PERIOD_W'(50);
         cycle_length_ff <= CYCLE_W'(10);
         bars_ff         <= '0;
         pos_ff          <= '0;
         iss_ff          <= '0;
         pend_ff         <= 1'b0;
         stage2_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_wr_en) begin
            unique case (csr_addr)
               CSR_FAST_PERIOD:  fast_period_ff  <= csr_wdata;
               CSR_SLOW_PERIOD:  slow_period_ff  <= csr_wdata;
               CSR_CYCLE_LENGTH: cycle_length_ff <= CYCLE_W'(csr_wdata);
               default: ;
            endcase
         end

         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         pend_ff <= 1'b0;

         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  close_ff  <= req_tdata;
                  stage2_ff <= 1'b0;
                  first_ff  <= req_tuser || (bars_ff == '0);
                  if (req_tuser) begin
                     bars_ff <= '0;
                     pos_ff  <= '0;
                  end
               end
            end
            ST_FAST_GO: begin
               neg_ff <= d_c[AVG_W];
               if (first_ff) begin
                  fast_ff <= x_c;
                  slow_ff <= x_c;
               end
            end
            ST_FAST_WAIT: begin
               if (div_done) begin
                  fast_ff <= neg_ff ? fast_ff - signed'(AVG_W'(div_quot))
                                    : fast_ff + signed'(AVG_W'(div_quot));
               end
            end
            ST_SLOW_GO: neg_ff <= d_c[AVG_W];
            ST_SLOW_WAIT: begin
               if (div_done) begin
                  slow_ff <= neg_ff ? slow_ff - signed'(AVG_W'(div_quot))
                                    : slow_ff + signed'(AVG_W'(div_quot));
               end
            end
            ST_DIFF: begin
               v_ff       <= diff_c;
               lo_ff      <= diff_c;
               hi_ff      <= diff_c;
               rd_addr_ff <= pos_dec_c;
               iss_ff     <= win_c - CNT_W'(1);
            end
            ST_SCAN: begin
               // issue one read a cycle, fold in the word read last cycle
               if (iss_ff != '0) begin
                  rd_addr_ff <= rd_dec_c;
                  iss_ff     <= iss_ff - CNT_W'(1);
                  pend_ff    <= 1'b1;
               end
               if (pend_ff) begin
                  if (sample_c < lo_ff) lo_ff <= sample_c;
                  if (sample_c > hi_ff) hi_ff <= sample_c;
               end
            end
            ST_RATIO: begin
               if (flat_c) begin
                  pct_ff <= PCT_HALF;
               end else if (full_c) begin
                  ratio_ff <= (RATIO_BITS+1)'(1) << RATIO_BITS;
               end
            end
            ST_DIV_WAIT: begin
               if (div_done) ratio_ff <= (RATIO_BITS+1)'(div_quot);
            end
            ST_PCT: pct_ff <= pct_sum_c[14 +: PCT_W];
            ST_SMOOTH: begin
               if (stage2_ff) begin
                  final_ff <= fin_new_c;
               end else begin
                  smooth_ff  <= sm_new_c;
                  v_ff       <= signed'({{(DIFF_W-PCT_W){1'b0}}, sm_new_c});
                  lo_ff      <= signed'({{(DIFF_W-PCT_W){1'b0}}, sm_new_c});
                  hi_ff      <= signed'({{(DIFF_W-PCT_W){1'b0}}, sm_new_c});
                  rd_addr_ff <= pos_dec_c;
                  iss_ff     <= win_c - CNT_W'(1);
                  stage2_ff  <= 1'b1;
               end
            end
            ST_DONE: begin
               if (out_free_c) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= (out_rnd_c > (PCT_W+1)'(OUT_MAX)) ? OUT_MAX
                                                                    : OUT_W'(out_rnd_c);
                  bars_ff      <= count_c;
                  pos_ff       <= (pos_ff == AW'(WINDOW_MAX - 1)) ? '0 : pos_ff + AW'(1);
               end
            end
            default: ;
         endcase
      end
   end

   sch_div #(
      .DIV_W(DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .rem_init (div_rem),
      .num      (div_num),
      .den      (div_den),
      .iters    (div_iters),
      .done     (div_done),
      .quot     (div_quot)
   );

   sch_hist #(
      .DEPTH  (WINDOW_MAX),
      .DIFF_W (DIFF_W)
   ) u_hist (
      .clock     (clock),
      .ctl       (mem_ctl),
      .wr_addr   (pos_ff),
      .rd_addr   (rd_addr_ff),
      .wr_diff   (diff_c),
      .wr_smooth (sm_new_c),
      .rd_diff   (rd_diff),
      .rd_smooth (rd_smooth)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

endmodule

>>> rtl/core/sch_div.sv
// Shared restoring divider, one quotient bit per cycle.
module sch_div #(
   parameter int DIV_W = 51
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [DIV_W-1:0]               rem_init,
   input  logic [DIV_W-1:0]               num,
   input  logic [DIV_W-1:0]               den,
   input  logic [$clog2(DIV_W+1)-1:0]     iters,
   output logic                           done,
   output logic [DIV_W-1:0]               quot
);
   import sch_pkg::*;

   localparam int CW = $clog2(DIV_W+1);

   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] num_ff, den_ff, quot_ff;
   logic [CW-1:0]    cnt_ff;
   logic             run_ff, done_ff;
   logic [DIV_W:0]   trial;
   logic             fits;

   assign trial  = {rem_ff, num_ff[DIV_W-1]};
   assign fits   = trial >= {1'b0, den_ff};
   assign rem_in = fits ? DIV_W'(trial - {1'b0, den_ff}) : trial[DIV_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            cnt_ff  <= iters;
            rem_ff  <= rem_init;
            num_ff  <= num;
            den_ff  <= den;
            quot_ff <= '0;
         end else if (run_ff) begin
            rem_ff  <= rem_in;
            num_ff  <= {num_ff[DIV_W-2:0], 1'b0};
            quot_ff <= {quot_ff[DIV_W-2:0], fits};
            cnt_ff  <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

>>> rtl/core/sch_hist.sv
// Ring histories of differences and smoothed values, registered read.
module sch_hist #(
   parameter int DEPTH  = 64,
   parameter int DIFF_W = 49
) (
   input  logic                             clock,
   input  sch_pkg::sch_mem_ctl_type         ctl,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   input  logic signed [DIFF_W-1:0]         wr_diff,
   input  logic [sch_pkg::PCT_W-1:0]        wr_smooth,
   output logic signed [DIFF_W-1:0]         rd_diff,
   output logic [sch_pkg::PCT_W-1:0]        rd_smooth
);
   import sch_pkg::*;

   logic signed [DIFF_W-1:0] diff_mem [DEPTH];
   logic [PCT_W-1:0]         smooth_mem [DEPTH];
   logic signed [DIFF_W-1:0] rd_diff_ff;
   logic [PCT_W-1:0]         rd_smooth_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_diff) begin
         diff_mem[wr_addr] <= wr_diff;
      end
      if (ctl.rd_en && !ctl.rd_smooth) begin
         rd_diff_ff <= diff_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_smooth) begin
         smooth_mem[wr_addr] <= wr_smooth;
      end
      if (ctl.rd_en && ctl.rd_smooth) begin
         rd_smooth_ff <= smooth_mem[rd_addr];
      end
   end

   assign rd_diff   = rd_diff_ff;
   assign rd_smooth = rd_smooth_ff;

endmodule

>>> tb/schaff_trend_cycle_tb.sv
// Testbench for the trend cycle block: self-checking stream test with a local predictor.
`timescale 1ns / 100ps

module schaff_trend_cycle_tb;
   import sch_pkg::*;

   localparam int WIN_MAX   = 64;
   localparam int FRAC      = 16;
   localparam int CYCLE_CAP = 3000000;
   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [31:0]           req_tdata;   // [31:0] close_price
   logic                  req_tuser;   // [0] restart
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [15:0]           rsp_tdata;   // [14:0] trend_value
   logic                  csr_wr_en;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [PERIOD_W-1:0]   csr_wdata;

   schaff_trend_cycle dut (.*);

   // predictor copy of registers and state
   logic [9:0]  fast_reg, slow_reg;
   logic [6:0]  cycle_reg;
   longint      fast_avg, slow_avg, smooth_avg, final_avg;
   longint      diff_hist [WIN_MAX];
   longint      smooth_hist [WIN_MAX];
   int unsigned ring_pos, bar_count;

   logic [OUT_W-1:0] trend_expected [$];
   int  fail_count;
   int  send_idle_pct, recv_idle_pct;
   int  recv_hold;
   longint cycle_count;
   int  price;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint ema_move(longint prev, longint x, int unsigned period);
      longint d;
      longint unsigned mag, den, q;
      d   = x - prev;
      mag = (d < 0) ? longint'(-d) : d;
      den = longint'((period == 0) ? 1 : period) + 1;
      q   = (2 * mag + den / 2) / den;
      return (d < 0) ? prev - longint'(q) : prev + longint'(q);
   endfunction

   // min-max stochastic over the newest win entries, percent in Q7.16
   function automatic longint window_percent(bit use_smooth, int unsigned pos,
                                             int unsigned win);
      longint v, lo, hi, e;
      longint unsigned a, b, r, q;
      v  = use_smooth ? smooth_hist[pos] : diff_hist[pos];
      lo = v;
      hi = v;
      for (int unsigned k = 1; k < win; k++) begin
         e = use_smooth ? smooth_hist[(pos + WIN_MAX - k) % WIN_MAX]
                        : diff_hist[(pos + WIN_MAX - k) % WIN_MAX];
         if (e < lo) lo = e;
         if (e > hi) hi = e;
      end
      if (hi == lo) return 3276800;
      a = v - lo;
      b = hi - lo;
      if (a >= b) begin
         q = 64'd1 << RATIO_BITS;
      end else begin
         r = a;
         q = 0;
         for (int k = 0; k < RATIO_BITS; k++) begin
            r = r << 1;
            q = q << 1;
            if (r >= b) begin
               r = r - b;
               q = q | 1;
            end
         end
      end
      return longint'((q * 100 + (64'd1 << (RATIO_BITS - 17))) >> (RATIO_BITS - 16));
   endfunction

   function automatic logic [OUT_W-1:0] trend_predict(logic [31:0] close, logic restart);
      int unsigned fp, sp, cyc, t, pos, count, win;
      longint x, fk, pf, res;
      bit first;
      fp  = fast_reg;
      sp  = slow_reg;
      cyc = cycle_reg;
      if (restart) begin
         bar_count = 0;
         ring_pos  = 0;
      end
      if (fp > sp) begin
         t  = fp;
         fp = sp;
         sp = t;
      end
      if (cyc == 0) cyc = 1;
      if (cyc > WIN_MAX) cyc = WIN_MAX;
      first = (bar_count == 0);
      pos   = ring_pos % WIN_MAX;
      x     = longint'(signed'(close)) * (64'sd1 << FRAC);
      if (first) begin
         fast_avg = x;
         slow_avg = x;
      end else begin
         fast_avg = ema_move(fast_avg, x, fp);
         slow_avg = ema_move(slow_avg, x, sp);
      end
      diff_hist[pos] = fast_avg - slow_avg;
      count = bar_count + 1;
      if (count > WIN_MAX) count = WIN_MAX;
      win = (cyc < count) ? cyc : count;
      fk = window_percent(1'b0, pos, win);
      smooth_avg = first ? fk : ema_move(smooth_avg, fk, 3);
      smooth_hist[pos] = smooth_avg;
      pf = window_percent(1'b1, pos, win);
      final_avg = first ? pf : ema_move(final_avg, pf, 3);
      ring_pos  = (pos + 1) % WIN_MAX;
      bar_count = count;
      res = final_avg;
      if (res < 0) res = 0;
      if (res > 6553600) res = 6553600;
      res = (res + 128) >>> 8;
      if (res > 25600) res = 25600;
      return OUT_W'(res);
   endfunction

   // receiver: random stall, or a long hold when requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (recv_hold > 0) begin
         recv_hold  <= recv_hold - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // compare each result word with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (trend_expected.size() == 0) begin
            $error("unexpected trend_value word: actual %0d", rsp_tdata[OUT_W-1:0]);
            fail_count++;
         end else begin
            if (rsp_tdata[OUT_W-1:0] !== trend_expected[0]) begin
               $error("trend_value mismatch: expected %0d actual %0d",
                      trend_expected[0], rsp_tdata[OUT_W-1:0]);
               fail_count++;
            end
            void'(trend_expected.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_bar(logic [31:0] close, logic restart);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= close;
      req_tuser  <= restart;
      trend_expected.push_back(trend_predict(close, restart));
      do @(posedge clock); while (!req_tready);
   endtask

   // drop valid and wait until every expected word is back, then let the block settle
   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (trend_expected.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   // one write cycle, then write enable drops so that back-to-back writes stay apart
   task automatic write_reg(logic [CSR_ADDR_W-1:0] idx, logic [PERIOD_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      if (idx == CSR_FAST_PERIOD) fast_reg = value;
      else if (idx == CSR_SLOW_PERIOD) slow_reg = value;
      else if (idx == CSR_CYCLE_LENGTH) cycle_reg = value[6:0];
   endtask

   task automatic set_periods(int fast, int slow, int cyc);
      write_reg(CSR_FAST_PERIOD, PERIOD_W'(fast));
      write_reg(CSR_SLOW_PERIOD, PERIOD_W'(slow));
      write_reg(CSR_CYCLE_LENGTH, PERIOD_W'(cyc));
   endtask

   function automatic logic [31:0] next_close();
      if ($urandom_range(99) < 5) begin
         price = $urandom;
      end else begin
         price = price + $urandom_range(0, 1 << 20) - (1 << 19);
      end
      return price;
   endfunction

   task automatic test_directed;
      // first bar on reset defaults, then field extremes
      send_bar(32'h8000_0000, 1'b0);
      send_bar(32'h7FFF_FFFF, 1'b0);
      send_bar(32'h0000_0000, 1'b0);
      send_bar(32'hFFFF_FFFF, 1'b0);
      // flat series after a restart
      send_bar(32'h0001_0000, 1'b1);
      repeat (4) send_bar(32'h0001_0000, 1'b0);
      drain();
      // fast above slow, window length zero (window of one); then zero periods, window length 127 (clamped to 64)
      set_periods(1023, 1, 0);
      send_bar(32'h0010_0000, 1'b1);
      send_bar(32'h0020_0000, 1'b0);
      send_bar(32'h0008_0000, 1'b0);
      drain();
      set_periods(0, 0, 127);
      write_reg(CSR_UNUSED, 10'h3FF);
      send_bar(32'h8000_0000, 1'b1);
      send_bar(32'h7FFF_FFFF, 1'b0);
      send_bar(32'h8000_0000, 1'b0);
      send_bar(32'h7FFF_FFFF, 1'b0);
      drain();
      set_periods(1023, 1023, 64);
      send_bar(32'h1234_5678, 1'b0);
      send_bar(32'hEDCB_A987, 1'b0);
      send_bar(32'h0000_0001, 1'b0);
      drain();
   endtask

   task automatic test_random_phase(int n_settings, int per_setting);
      for (int s = 0; s < n_settings; s++) begin
         case ($urandom_range(3))
            0: set_periods($urandom_range(1, 30), $urandom_range(1, 60), $urandom_range(1, 16));
            1: set_periods($urandom_range(0, 1023), $urandom_range(0, 1023),
                           $urandom_range(0, 127));
            2: set_periods($urandom_range(2, 12), $urandom_range(10, 40), 64);
            default: set_periods(1, 1023, $urandom_range(1, 64));
         endcase
         price = $urandom_range(0, 1 << 24);
         send_bar(next_close(), 1'b1);
         for (int i = 1; i < per_setting; i++)
            send_bar(next_close(), ($urandom_range(99) < 3));
         drain();
      end
   endtask

   // long receiver hold while bars keep coming, so the input stalls
   task automatic test_backpressure;
      recv_hold = 3000;
      for (int i = 0; i < 8; i++) send_bar(next_close(), 1'b0);
      drain();
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = 1'b0;
      csr_wr_en     = 1'b0;
      csr_addr      = '0;
      csr_wdata     = '0;
      fail_count    = 0;
      recv_hold     = 0;
      cycle_count   = 0;
      send_idle_pct = 10;
      recv_idle_pct = 71;
      fast_reg      = 10'd23;
      slow_reg      = 10'd50;
      cycle_reg     = 7'd10;
      fast_avg      = 0;
      slow_avg      = 0;
      smooth_avg    = 0;
      final_avg     = 0;
      ring_pos      = 0;
      bar_count     = 0;
      price         = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_phase(4, 140);
      test_backpressure();
      send_idle_pct = 71;
      recv_idle_pct = 10;
      test_random_phase(4, 140);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_phase(4, 140);

      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
